[src/cmazs_pkg.sv]
// Shared widths, register indexes and the divider request type for the moving-average unit.
package cmazs_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int SUM_W      = 29;
	localparam int CNT_W      = 5;
	localparam int WS_W       = 5;
	localparam int QUO_W      = 28;
	localparam int REG_ADDR_W = 1;
	localparam int REG_DATA_W = 5;

	localparam logic [REG_ADDR_W-1:0] REG_WINDOW_SIZE = 1'd0;
	localparam logic [REG_ADDR_W-1:0] REG_SKIP_ZEROS  = 1'd1;

	localparam logic [WS_W-1:0] WINDOW_SIZE_RESET = 5'd3;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [QUO_W-1:0] mag;
		logic [CNT_W-1:0] den;
	} div_req_t;

endpackage

[src/centered_moving_average_zero_skip_unit.sv]
// Centered moving average over an odd window of Q8.16 samples, with optional zero skipping.
// One sample word in gives one smoothed word out, for the center of the window, i.e. half a
// window late. After a word is taken the history chain of MAX_WINDOW cells is rotated once
// around to add up the window, then a one-bit-per-cycle divider forms the quotient. The
// result word is placed once the division is done, or once the sum is done when skip_zeros
// is set and the center sample is zero (that word is zero and the divider does not run); the
// input opens for the next sample as the result word is placed. A stalled output holds the
// unit until the word leaves. A finished word waits in the output register while the next
// sample is already taken. The window size and skip_zeros registers are written through the
// cfg port, which is always ready; write them only while the unit is idle.
module centered_moving_average_zero_skip_unit #(
	parameter int MAX_WINDOW = 31
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,  // [23:0] sample_in
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,  // [23:0] smoothed
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cmazs_pkg::REG_ADDR_W-1:0] cfg_addr,
	input  logic [cmazs_pkg::REG_DATA_W-1:0] cfg_data
);
	import cmazs_pkg::*;

	localparam int AW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (AW > WS_W) ? AW : WS_W;
	localparam logic [CW-1:0] LIM =
		CW'(((MAX_WINDOW % 2) == 0) ? (MAX_WINDOW - 1) : MAX_WINDOW);

	typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_START, ST_DIV, ST_OUT} state_t;

	state_t              state_q;
	logic [WS_W-1:0]     ws_q;
	logic                skip_cfg_q;
	logic [WS_W-1:0]     w_q;
	logic                skip_q;
	logic [AW-1:0]       age_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                cz_q;
	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] m_tdata_q;

	logic                accept;
	logic                shift_en;
	logic [SAMPLE_W-1:0] chain_in;
	logic [SAMPLE_W-1:0] cell_q [MAX_WINDOW];
	logic [SAMPLE_W-1:0] tail;
	logic [WS_W-1:0]     w_raw;
	logic [WS_W-1:0]     w_eff;
	logic                in_win;
	logic                at_center;
	logic                take;
	logic                out_free;
	div_req_t            div_req;
	logic                div_done;
	logic [SAMPLE_W-1:0] div_quo;
	logic [SUM_W-1:0]    sum_abs;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	// effective window: at least 1, odd, within the chain
	assign w_raw = (ws_q == '0) ? WS_W'(1) : (ws_q | WS_W'(1));
	assign w_eff = (CW'(w_raw) > LIM) ? LIM[WS_W-1:0] : w_raw;

	// new sample enters at the head; during the sum the tail wraps to the head
	assign shift_en = accept || (state_q == ST_ACC);
	assign chain_in = (state_q == ST_IDLE) ? s_tdata : tail;
	assign tail     = cell_q[MAX_WINDOW-1];

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			cmazs_cell u_cell (.clk, .arst_n, .en(shift_en), .d(chain_in), .q(cell_q[i]));
		end else begin : g_body
			cmazs_cell u_cell (.clk, .arst_n, .en(shift_en), .d(cell_q[i-1]), .q(cell_q[i]));
		end
	end

	// the tail shows the sample of age age_q
	assign in_win    = CW'(age_q) < CW'(w_q);
	assign at_center = CW'(age_q) == CW'(w_q >> 1);
	assign take      = in_win && (!skip_q || (tail != '0));

	assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	always_comb begin
		div_req.start = (state_q == ST_START) && !(skip_q && cz_q);
		div_req.neg   = sum_q[SUM_W-1];
		div_req.mag   = sum_abs[QUO_W-1:0];
		div_req.den   = cnt_q;
	end

	cmazs_div u_div (.clk, .arst_n, .req(div_req), .done(div_done), .quo(div_quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			ws_q       <= WINDOW_SIZE_RESET;
			skip_cfg_q <= 1'b0;
			age_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_addr)
					REG_WINDOW_SIZE: ws_q       <= cfg_data[WS_W-1:0];
					REG_SKIP_ZEROS:  skip_cfg_q <= cfg_data[0];
					default: ;
				endcase
			end
			// in the output state the word is replaced instead
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						age_q   <= AW'(MAX_WINDOW - 1);
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					age_q <= age_q - 1'b1;
					if (age_q == '0) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= (skip_q && cz_q) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q    <= w_eff;
			skip_q <= skip_cfg_q;
			sum_q  <= '0;
			cnt_q  <= '0;
			cz_q   <= 1'b0;
		end else if (state_q == ST_ACC) begin
			if (take) begin
				sum_q <= sum_q + SUM_W'(signed'(tail));
				cnt_q <= cnt_q + 1'b1;
			end
			if (at_center && (tail == '0)) begin
				cz_q <= 1'b1;
			end
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= (skip_q && cz_q) ? '0 : div_quo;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[src/cmazs_cell.sv]
// One history cell of the sample chain: loads its neighbor's sample when the chain moves.
module cmazs_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [cmazs_pkg::SAMPLE_W-1:0] d,
	output logic [cmazs_pkg::SAMPLE_W-1:0] q
);
	import cmazs_pkg::*;

	logic [SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

[src/cmazs_div.sv]
// Serial restoring divider: one quotient bit per cycle, sign applied at the end.
module cmazs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmazs_pkg::div_req_t            req,
	output logic                           done,
	output logic [cmazs_pkg::SAMPLE_W-1:0] quo
);
	import cmazs_pkg::*;

	localparam int STEP_W = $clog2(QUO_W);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [QUO_W-1:0]    dvd_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    den_q;
	logic                neg_q;
	logic [CNT_W:0]      trial;
	logic                fits;
	logic [SAMPLE_W-1:0] mag_lo;

	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.mag;
			den_q <= req.den;
			neg_q <= req.neg;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when the divisor fits
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], fits};
		end
	end

	assign mag_lo = dvd_q[SAMPLE_W-1:0];
	assign quo    = neg_q ? SAMPLE_W'(-mag_lo) : mag_lo;
	assign done   = done_q;

endmodule

[src/cmazs_chk.sv]
// Port-level checks for the moving-average unit, bound to the top level.
module cmazs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        cfg_ready
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped or changed while stalled");

	// one sample at a time: input closes right after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second sample taken while one is in work");

	// a new result only ends a busy period
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a sample in work");

	// input reopens only when the previous result has been placed
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("input reopened without a result word");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind centered_moving_average_zero_skip_unit cmazs_chk u_cmazs_chk (.*);

[tb/tb_top.sv]
// Self-checking testbench for the centered moving-average unit with zero skipping.
`timescale 1ns / 100ps

module tb_top;
	import cmazs_pkg::*;

	localparam int MAX_WIN = 31;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [REG_ADDR_W-1:0] cfg_addr;
	logic [REG_DATA_W-1:0] cfg_data;

	// Shadow of the unit: sample history, write slot and both registers
	logic signed [23:0] hist_q [MAX_WIN];
	int                 hist_wr;
	logic [WS_W-1:0]    win_size_q;
	logic               skip_zeros_q;

	logic [23:0] exp_smoothed_q [$];
	int          err_cnt;
	bit          idle_on;
	int          rx_stall = 0;

	centered_moving_average_zero_skip_unit #(
		.MAX_WINDOW(MAX_WIN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [23:0] sample_at_age(int age);
		return hist_q[(hist_wr + 2 * MAX_WIN - 1 - age) % MAX_WIN];
	endfunction

	// Push one sample into the shadow history and return the smoothed center value
	function automatic logic [23:0] predict_smoothed(logic [23:0] sample);
		int                 w;
		int                 a;
		longint             acc;
		longint             cnt;
		longint             avg;
		logic signed [23:0] v;
		hist_q[hist_wr] = sample;
		hist_wr = (hist_wr + 1) % MAX_WIN;
		w = win_size_q;
		if (w < 1) w = 1;
		if (w % 2 == 0) w++;
		if (w > MAX_WIN) w = MAX_WIN;
		acc = 0;
		cnt = 0;
		if (skip_zeros_q && sample_at_age(w / 2) == 0) begin
			avg = 0;
		end else begin
			for (a = 0; a < w; a++) begin
				v = sample_at_age(a);
				if (!skip_zeros_q || v != 0) begin
					acc += v;
					cnt++;
				end
			end
			avg = acc / cnt;
		end
		return avg[23:0];
	endfunction

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 9))
			0, 1, 2: return 24'd0;
			3:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			4, 5:    return 24'($signed($urandom_range(0, 63)) - 32);
			default: return 24'($urandom());
		endcase
	endfunction

	// Call and return just after a falling edge; valid stays up unless a gap follows
	task automatic send_sample(logic [23:0] sample);
		int gap;
		gap = idle_on ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = sample;
		do @(posedge clk); while (!s_tready);
		exp_smoothed_q.push_back(predict_smoothed(sample));
		@(negedge clk);
	endtask

	// Hold the input and wait until every expected word has come back
	task automatic settle_idle();
		s_tvalid = 1'b0;
		while (exp_smoothed_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_ADDR_W-1:0] addr, logic [REG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_addr  = addr;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (addr)
			REG_WINDOW_SIZE: win_size_q = data;
			REG_SKIP_ZEROS:  skip_zeros_q = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Early windows in skip mode see cleared history, which must not count
	task automatic test_stream_start_skip();
		write_reg(REG_SKIP_ZEROS, 5'd1);
		write_reg(REG_WINDOW_SIZE, 5'd7);
		send_sample(24'd5);
		send_sample(24'd0);
		send_sample(-24'sd3);
		send_sample(24'd100);
		send_sample(24'd0);
		send_sample(24'd0);
		send_sample(24'd7);
		settle_idle();
	endtask

	task automatic test_field_extremes();
		write_reg(REG_SKIP_ZEROS, 5'd0);
		write_reg(REG_WINDOW_SIZE, WINDOW_SIZE_RESET);
		repeat (3) send_sample(24'h7FFFFF);
		repeat (3) send_sample(24'h800000);
		send_sample(24'h000001);
		send_sample(24'hFFFFFF);
		settle_idle();
	endtask

	// Zero rounds up to one, even sizes round up, all ones is the largest window
	task automatic test_window_sizes();
		write_reg(REG_WINDOW_SIZE, 5'd0);
		send_sample(24'h123456);
		settle_idle();
		write_reg(REG_WINDOW_SIZE, 5'd2);
		send_sample(24'hFEDCBA);
		send_sample(24'h000003);
		settle_idle();
		write_reg(REG_WINDOW_SIZE, 5'd31);
		send_sample(24'h7FFFFF);
		send_sample(24'h400000);
		settle_idle();
		write_reg(REG_WINDOW_SIZE, 5'd30);
		send_sample(24'h800001);
		settle_idle();
	endtask

	task automatic test_random_phases();
		int phase;
		int n;
		logic [WS_W-1:0] ws;
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0:       ws = 5'd31;
				1:       ws = 5'd0;
				2:       ws = 5'd1;
				3:       ws = 5'd30;
				default: ws = WS_W'($urandom_range(0, 31));
			endcase
			write_reg(REG_WINDOW_SIZE, ws);
			write_reg(REG_SKIP_ZEROS, (phase < 2) ? 5'(phase ^ 1) : 5'($urandom_range(0, 1)));
			idle_on = (phase % 3 != 2);
			for (n = 0; n < 38; n++) begin
				if (phase == 4 && n == 19) settle_idle();
				send_sample(rand_sample());
			end
			settle_idle();
		end
	endtask

	// Receiver side: random back-pressure while idling is on
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			m_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 3) == 0) rx_stall <= gap_len();
		end
	end

	always @(posedge clk) begin
		logic [23:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_smoothed_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("%0t: unexpected word smoothed=%0d", $realtime, $signed(m_tdata));
			end else begin
				want = exp_smoothed_q.pop_front();
				if (m_tdata !== want) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: smoothed mismatch, expected %0d, got %0d",
							$realtime, $signed(want), $signed(m_tdata));
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_valid    = 1'b0;
		cfg_addr     = '0;
		cfg_data     = '0;
		err_cnt      = 0;
		idle_on      = 1'b1;
		hist_wr      = 0;
		win_size_q   = WINDOW_SIZE_RESET;
		skip_zeros_q = 1'b0;
		for (int i = 0; i < MAX_WIN; i++) hist_q[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_stream_start_skip();
		test_field_extremes();
		test_window_sizes();
		test_random_phases();

		settle_idle();
		repeat (2 * MAX_WIN + 40) @(negedge clk);
		if (err_cnt == 0 && exp_smoothed_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
